### src/sbe_pkg.sv
// Shared types, character codes and helper functions for the sixel band encoder.
`timescale 1ns / 1ps

package sbe_pkg;

    localparam int CHUNK_CHARS_DEF = 1024;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int COL_W  = 24;
    localparam int BAND_W = 2;
    localparam int CHAR_W = 8;
    localparam int BCD_W  = 16;
    localparam int SLOT_N = 14;

    localparam logic [CHAR_W-1:0] CH_BANG    = 8'h21;
    localparam logic [CHAR_W-1:0] CH_DASH    = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_RETURN  = 8'h24;
    localparam logic [CHAR_W-1:0] CH_ST      = 8'h9C;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] SIXEL_BIAS = 8'h3F;

    localparam logic [BAND_W-1:0] BAND_FINAL = 2'd3;

    localparam logic [BCD_W-1:0] BCD_ONE = 16'h0001;
    localparam logic [BCD_W-1:0] BCD_MAX = 16'h9999;

    // One run to be written out: bare character or '!' count character.
    typedef struct packed {
        logic              valid;
        logic [CHAR_W-1:0] chr;
        logic [BCD_W-1:0]  bcd;
    } flush_t;

    // Everything one column produces, in output order.
    typedef struct packed {
        flush_t            run_a;
        flush_t            run_b;
        logic              term;
        logic [CHAR_W-1:0] term_chr;
    } cmd_t;

    function automatic logic [CHAR_W-1:0] sixel_char(input logic [COL_W-1:0] col,
                                                     input logic [BAND_W-1:0] band);
        logic [5:0] s;
        logic [5:0] r;
        int         b;
        case (band)
            2'd0:    s = col[23:18];
            2'd1:    s = col[17:12];
            2'd2:    s = col[11:6];
            default: s = col[5:0];
        endcase
        // top pixel goes to bit 0
        for (b = 0; b < 6; b++) begin
            r[5-b] = s[b];
        end
        return {2'b00, r} + SIXEL_BIAS;
    endfunction

    function automatic logic [BCD_W-1:0] bcd_inc(input logic [BCD_W-1:0] v);
        logic [BCD_W-1:0] res;
        logic [3:0]       nib;
        logic             carry;
        int               d;
        res   = '0;
        carry = 1'b1;
        for (d = 0; d < 4; d++) begin
            nib = v[4*d +: 4] + {3'b000, carry};
            if (nib > 4'd9) begin
                nib   = 4'd0;
                carry = 1'b1;
            end
            else begin
                carry = 1'b0;
            end
            res[4*d +: 4] = nib;
        end
        // saturate at 9999
        if (v == BCD_MAX) begin
            res = v;
        end
        return res;
    endfunction

endpackage

### src/sixel_band_encoder_rle.sv
// Top level of the sixel band encoder with run-length coding.
//
// Input stream: one print-head column per word. tdata carries the 24-bit column,
// tuser the band (0..3), tlast marks the last column of a band pass.
// Output stream: one sixel byte per word, tlast set on the final byte that an
// input column produces. A column that only lengthens a run produces no bytes.
// The run tracker takes a column while the queue has room; up to 9 bytes per column
// leave at one byte per cycle through the serializer while the receiver is ready,
// so the sustained column rate is one per cycle while runs are long and is set by
// the emitted bytes otherwise. A queue of QUEUE_DEPTH commands sits between tracker
// and serializer. A column's first byte waits for its command to pass the queue and
// then the output register, and a stall at the receiver can delay it further.
// Reset clears the open run, the chunk position and the queue; the output is
// empty after reset. When the receiver stalls, the output word holds, the
// serializer waits, and input tready drops once the queue fills.
`timescale 1ns / 1ps

module sixel_band_encoder_rle #(
    parameter int CHUNK_CHARS = sbe_pkg::CHUNK_CHARS_DEF,
    parameter int QUEUE_DEPTH = sbe_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [sbe_pkg::COL_W-1:0]  s_axis_tdata,   // [23:0] column_bits
    input  logic [sbe_pkg::BAND_W-1:0] s_axis_tuser,   // [1:0] band
    input  logic                       s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [sbe_pkg::CHAR_W-1:0] m_axis_tdata,   // [7:0] out_byte
    output logic                       m_axis_tlast
);

    sbe_pkg::cmd_t push_cmd;
    sbe_pkg::cmd_t head;
    logic          push;
    logic          full;
    logic          pop;
    logic          head_valid;

    sbe_front #(
        .CHUNK_CHARS (CHUNK_CHARS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .column_bits (s_axis_tdata),
        .band        (s_axis_tuser),
        .last_column (s_axis_tlast),
        .queue_full  (full),
        .push        (push),
        .cmd         (push_cmd)
    );

    sbe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    sbe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_byte   (m_axis_tdata),
        .out_last   (m_axis_tlast)
    );

endmodule

### src/sbe_front.sv
// Front end: converts columns to sixel characters and tracks runs and chunks.
`timescale 1ns / 1ps

module sbe_front #(
    parameter int CHUNK_CHARS = sbe_pkg::CHUNK_CHARS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [sbe_pkg::COL_W-1:0]  column_bits,
    input  logic [sbe_pkg::BAND_W-1:0] band,
    input  logic                       last_column,
    input  logic                       queue_full,
    output logic                       push,
    output sbe_pkg::cmd_t              cmd
);

    localparam int CW = $clog2(CHUNK_CHARS + 1);

    logic [sbe_pkg::CHAR_W-1:0] held_reg, held_next;
    logic [sbe_pkg::BCD_W-1:0]  bcd_reg, bcd_next;
    logic                       holding_reg, holding_next;
    logic [CW-1:0]              chunk_reg, chunk_next;

    logic [sbe_pkg::CHAR_W-1:0] chr;
    logic [sbe_pkg::BCD_W-1:0]  cur_bcd;
    logic [CW-1:0]              chunk_inc;
    logic                       extend;
    logic                       close;
    logic                       accept;

    assign in_ready  = !queue_full;
    assign accept    = in_valid && in_ready;
    assign chr       = sbe_pkg::sixel_char(column_bits, band);
    assign extend    = holding_reg && (held_reg == chr);
    assign cur_bcd   = extend ? sbe_pkg::bcd_inc(bcd_reg) : sbe_pkg::BCD_ONE;
    assign chunk_inc = chunk_reg + 1'b1;
    assign close     = (chunk_inc >= CW'(CHUNK_CHARS)) || last_column;

    always_comb
    begin
        cmd.run_a.valid = holding_reg && !extend;
        cmd.run_a.chr   = held_reg;
        cmd.run_a.bcd   = bcd_reg;
        cmd.run_b.valid = close;
        cmd.run_b.chr   = chr;
        cmd.run_b.bcd   = cur_bcd;
        cmd.term        = last_column;
        cmd.term_chr    = (band == sbe_pkg::BAND_FINAL) ? sbe_pkg::CH_ST : sbe_pkg::CH_RETURN;
    end

    // drop words that only extend a run
    assign push = accept && (cmd.run_a.valid || cmd.run_b.valid || cmd.term);

    always_comb
    begin
        held_next    = held_reg;
        bcd_next     = bcd_reg;
        holding_next = holding_reg;
        chunk_next   = chunk_reg;
        if (accept) begin
            if (close) begin
                held_next    = '0;
                bcd_next     = '0;
                holding_next = 1'b0;
                chunk_next   = '0;
            end
            else begin
                held_next    = chr;
                bcd_next     = cur_bcd;
                holding_next = 1'b1;
                chunk_next   = chunk_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            held_reg    <= '0;
            bcd_reg     <= '0;
            holding_reg <= 1'b0;
            chunk_reg   <= '0;
        end
        else begin
            held_reg    <= held_next;
            bcd_reg     <= bcd_next;
            holding_reg <= holding_next;
            chunk_reg   <= chunk_next;
        end
    end

    a_chunk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        chunk_reg < CW'(CHUNK_CHARS))
        else $error("chunk position reached the chunk size");

endmodule

### src/sbe_queue.sv
// Short command queue between the run tracker and the byte serializer.
`timescale 1ns / 1ps

module sbe_queue #(
    parameter int DEPTH = sbe_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sbe_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output sbe_pkg::cmd_t head
);

    localparam int PW  = $clog2(DEPTH);
    localparam int CNW = $clog2(DEPTH + 1);

    sbe_pkg::cmd_t  mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNW-1:0] count_reg, count_next;

    assign full       = (count_reg == CNW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !head_valid))
        else $error("pop from an empty queue");

endmodule

### src/sbe_back.sv
// Back end: serializes one queued command into output bytes behind an output register.
`timescale 1ns / 1ps

module sbe_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       head_valid,
    input  sbe_pkg::cmd_t              head,
    output logic                       pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [sbe_pkg::CHAR_W-1:0] out_byte,
    output logic                       out_last
);

    localparam int N = sbe_pkg::SLOT_N;

    logic [N-1:0] done_reg, done_next;
    logic         out_valid_reg;
    logic [sbe_pkg::CHAR_W-1:0] out_byte_reg;
    logic         out_last_reg;

    logic [N-1:0] enable;
    logic [N-1:0] remaining;
    logic [N-1:0] pick;
    logic [N-1:0] rest;
    logic [sbe_pkg::CHAR_W-1:0] slot_byte [N];
    logic [sbe_pkg::CHAR_W-1:0] sel_byte;
    logic         is_last;
    logic         advance;

    function automatic logic [5:0] run_slots(input sbe_pkg::flush_t f);
        logic multi;
        multi = f.valid && (f.bcd != sbe_pkg::BCD_ONE);
        // bang, thousands, hundreds, tens, units, character; no leading zeros
        return {f.valid,
                multi,
                multi && (f.bcd[15:4] != '0),
                multi && (f.bcd[15:8] != '0),
                multi && (f.bcd[15:12] != '0),
                multi};
    endfunction

    always_comb
    begin
        slot_byte[0]  = sbe_pkg::CH_BANG;
        slot_byte[1]  = sbe_pkg::CH_ZERO + {4'h0, head.run_a.bcd[15:12]};
        slot_byte[2]  = sbe_pkg::CH_ZERO + {4'h0, head.run_a.bcd[11:8]};
        slot_byte[3]  = sbe_pkg::CH_ZERO + {4'h0, head.run_a.bcd[7:4]};
        slot_byte[4]  = sbe_pkg::CH_ZERO + {4'h0, head.run_a.bcd[3:0]};
        slot_byte[5]  = head.run_a.chr;
        slot_byte[6]  = sbe_pkg::CH_BANG;
        slot_byte[7]  = sbe_pkg::CH_ZERO + {4'h0, head.run_b.bcd[15:12]};
        slot_byte[8]  = sbe_pkg::CH_ZERO + {4'h0, head.run_b.bcd[11:8]};
        slot_byte[9]  = sbe_pkg::CH_ZERO + {4'h0, head.run_b.bcd[7:4]};
        slot_byte[10] = sbe_pkg::CH_ZERO + {4'h0, head.run_b.bcd[3:0]};
        slot_byte[11] = head.run_b.chr;
        slot_byte[12] = sbe_pkg::CH_DASH;
        slot_byte[13] = head.term_chr;
    end

    assign enable    = {head.term, head.term, run_slots(head.run_b), run_slots(head.run_a)};
    assign remaining = enable & ~done_reg;
    assign pick      = remaining & (~remaining + 1'b1);
    assign rest      = remaining & ~pick;
    assign is_last   = (rest == '0);

    always_comb
    begin
        sel_byte = '0;
        for (int i = 0; i < N; i++) begin
            sel_byte = sel_byte | (slot_byte[i] & {sbe_pkg::CHAR_W{pick[i]}});
        end
    end

    // load the output register when it is empty or being drained
    assign advance = head_valid && (!out_valid_reg || out_ready);
    assign pop     = advance && is_last;

    always_comb
    begin
        done_next = done_reg;
        if (advance) begin
            done_next = is_last ? '0 : (done_reg | pick);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            done_reg <= done_next;
            if (advance) begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            out_byte_reg <= sel_byte;
            out_last_reg <= is_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

    a_cmd_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (enable != '0))
        else $error("queued command carries no bytes");

    a_done_subset: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> ((done_reg & ~enable) == '0))
        else $error("serializer progress outside the command's bytes");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> (done_reg == '0))
        else $error("serializer progress left over with no command");

endmodule
